@@ rtl/mf3_pkg.sv @@
package mf3_pkg;

    // Field and register widths
    localparam int PX_W       = 8;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 13;
    localparam int OUT_ROW_W  = 12;
    localparam int OUT_COL_W  = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Image size limits and reset size
    localparam int MIN_DIM    = 3;
    localparam int MAX_HEIGHT = 4096;
    localparam int RST_WIDTH  = 1024;
    localparam int RST_HEIGHT = 1024;

    // Result queue sizing
    localparam int QUEUE_DEPTH = 8;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef logic [PX_W-1:0] t_px;

    // One window column, top row first; after sorting, [0] is the minimum
    typedef t_px [2:0] t_col;

    // Three window columns, oldest first
    typedef t_col [2:0] t_win;

    typedef struct packed {
        logic [PX_W-1:0] pixel;
        logic            frame_start;
    } t_in;

    typedef struct packed {
        logic [PX_W-1:0]      value;
        logic [OUT_ROW_W-1:0] out_row;
        logic [OUT_COL_W-1:0] out_col;
        logic                 from_median;
        logic                 last;
    } t_out;

    // Per-pixel tag carried down the pipeline
    typedef struct packed {
        logic                 border;
        logic                 med;
        logic [PX_W-1:0]      px;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
    } t_ctl;

    // Queue entry: one pixel's border copy and/or median
    typedef struct packed {
        t_ctl            ctl;
        logic [PX_W-1:0] median;
    } t_qent;

    function automatic t_px min2(input t_px a, input t_px b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_px max2(input t_px a, input t_px b);
        return (a < b) ? b : a;
    endfunction

    function automatic t_px med3(input t_px a, input t_px b, input t_px c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Three compare-exchange steps
    function automatic t_col sort3(input t_col v);
        t_col s;
        s = v;
        if (s[0] > s[1]) begin
            s[0] = v[1];
            s[1] = v[0];
        end
        if (s[1] > s[2]) begin
            s[2] = s[1];
            s[1] = v[2];
        end
        if (s[0] > s[1]) begin
            s = {s[2], s[0], s[1]};
        end
        return s;
    endfunction

endpackage

@@ rtl/mf3_ram.sv @@
module mf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mf3_cell.sv @@
module mf3_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  mf3_pkg::t_col i_col,
    output mf3_pkg::t_col o_col
);

    import mf3_pkg::*;

    t_col r_col;

    // Load the incoming column (the new one or the neighbor's), kept in sorted order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= sort3(i_col);
        end
    end

    assign o_col = r_col;

endmodule

@@ rtl/mf3_sort.sv @@
module mf3_sort (
    input  logic          i_clk,
    input  mf3_pkg::t_win i_win,
    output mf3_pkg::t_px  o_med
);

    import mf3_pkg::*;

    t_px r_lo;
    t_px r_mid;
    t_px r_hi;
    t_px r_med;

    // Reduce sorted columns: max of minima, median of middles, min of maxima
    always_ff @(posedge i_clk) begin
        r_lo  <= max2(max2(i_win[0][0], i_win[1][0]), i_win[2][0]);
        r_mid <= med3(i_win[0][1], i_win[1][1], i_win[2][1]);
        r_hi  <= min2(min2(i_win[0][2], i_win[1][2]), i_win[2][2]);
        r_med <= med3(r_lo, r_mid, r_hi);
    end

    assign o_med = r_med;

endmodule

@@ rtl/mf3_outq.sv @@
module mf3_outq #(
    parameter int DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  mf3_pkg::t_qent             i_push_data,
    output logic                       o_valid,
    output mf3_pkg::t_out              o_data,
    input  logic                       i_stall,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    import mf3_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_qent            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             r_border_done;

    t_qent ent;
    logic  show_border;
    logic  take;
    logic  pop;

    // Present the head entry: border copy first, then the median
    always_comb begin
        ent                = r_mem[r_rd];
        show_border        = ent.ctl.border && !r_border_done;
        o_data.value       = show_border ? ent.ctl.px : ent.median;
        o_data.out_row     = show_border ? ent.ctl.row : ent.ctl.row - 1'b1;
        o_data.out_col     = show_border ? ent.ctl.col : ent.ctl.col - 1'b1;
        o_data.from_median = !show_border;
        o_data.last        = !(show_border && ent.ctl.med);
    end

    assign o_valid = (r_cnt != '0);
    assign take    = o_valid && !i_stall;
    assign pop     = take && o_data.last;
    assign o_count = r_cnt;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr          <= '0;
            r_rd          <= '0;
            r_cnt         <= '0;
            r_border_done <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd          <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
                r_border_done <= 1'b0;
            end else if (take) begin
                r_border_done <= 1'b1;
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/median_filter_3x3_core.sv @@
// 3x3 median filter for 8-bit grayscale pixels streamed in raster order.
// Input channel: i_in_valid / o_in_stall carry one pixel per transaction, with
// frame_start set on the first pixel of a frame to return to row 0, column 0.
// Output channel: o_out_valid / i_out_stall carry one result per transaction.
// Each pixel yields zero, one or two results: a border pixel (first or last
// row or column) is copied out first, then, once the window spans three rows
// and three columns, the median of the window tagged with the window centre.
// last marks the final result of a pixel.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (0: image
// width, 1: image height); write only while no transaction is in flight.
// Throughput: one pixel per clock while o_in_stall is low. The limit is the output
// channel, which moves one result a clock unless stalled, so a pixel with two results holds it for both.
// Path: the first result of a pixel can be taken once the pixel has passed the line
// buffer read, window cells, two median stages and the queue.
// An 8-entry result queue absorbs output stalls; o_in_stall rises only when
// the queue plus the pixels in the pipeline would fill it.
// Reset clears position, window, pipeline and queue, and sets the image size
// to 1024 x 1024. Line buffer contents are not cleared.
module median_filter_3x3_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  mf3_pkg::t_in                   i_in_data,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output mf3_pkg::t_out                  o_out_data,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mf3_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import mf3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    function automatic logic [COL_W-1:0] clamp_w(input logic [COL_W-1:0] v);
        if (v < COL_W'(MIN_DIM)) begin
            return COL_W'(MIN_DIM);
        end
        if (int'(v) > MAX_WIDTH) begin
            return COL_W'(MAX_WIDTH);
        end
        return v;
    endfunction

    function automatic logic [ROW_W-1:0] clamp_h(input logic [ROW_W-1:0] v);
        if (v < ROW_W'(MIN_DIM)) begin
            return ROW_W'(MIN_DIM);
        end
        if (int'(v) > MAX_HEIGHT) begin
            return ROW_W'(MAX_HEIGHT);
        end
        return v;
    endfunction

    // Configuration (stored already clamped)
    logic [COL_W-1:0] r_w;
    logic [COL_W-1:0] r_w_m1;
    logic [ROW_W-1:0] r_h;
    logic [ROW_W-1:0] r_h_m1;

    // Position of the next pixel
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    // Pipeline stages
    logic          r_a_valid;
    logic          r_b_valid;
    logic          r_c_valid;
    logic          r_d_valid;
    t_ctl          r_a_ctl;
    t_ctl          r_b_ctl;
    t_ctl          r_c_ctl;
    t_ctl          r_d_ctl;
    logic [AW-1:0] r_a_addr;

    // Line buffer bypass for back-to-back access to one column
    logic                 r_byp;
    logic [2*PX_W-1:0]    r_byp_data;

    logic             accept;
    logic [COL_W-1:0] c_base;
    logic [ROW_W-1:0] r_base;
    logic [COL_W-1:0] c_pos;
    logic [ROW_W-1:0] r_inc;
    logic [ROW_W-1:0] r_pos;
    logic             at_last_col;
    logic             at_last_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    t_ctl             n_a_ctl;

    logic [AW-1:0]        ram_raddr;
    logic [2*PX_W-1:0]    ram_rdata;
    logic [2*PX_W-1:0]    ram_wdata;
    logic [2*PX_W-1:0]    lines;
    t_px                  above1;
    t_px                  above2;
    t_col                 new_col;
    t_win                 win;
    t_px                  median;
    t_qent                q_push_data;
    logic                 q_push;
    logic [QCNT_W-1:0]    q_count;

    // Accept while the queue can hold every pixel in flight plus this one
    assign o_in_stall = (int'(q_count)
                         + $countones({r_a_valid, r_b_valid, r_c_valid, r_d_valid})
                         >= QUEUE_DEPTH);
    assign accept = i_in_valid && !o_in_stall;

    // Resolve the position of the incoming pixel
    always_comb begin
        c_base = i_in_data.frame_start ? '0 : r_col;
        r_base = i_in_data.frame_start ? '0 : r_row;
        if (c_base >= r_w) begin
            c_pos = '0;
            r_inc = r_base + 1'b1;
        end else begin
            c_pos = c_base;
            r_inc = r_base;
        end
        r_pos       = (r_inc >= r_h) ? '0 : r_inc;
        at_last_col = (c_pos == r_w_m1);
        at_last_row = (r_pos == r_h_m1);

        if (at_last_col) begin
            n_col = '0;
            n_row = at_last_row ? '0 : r_pos + 1'b1;
        end else begin
            n_col = c_pos + 1'b1;
            n_row = r_pos;
        end

        n_a_ctl.border = (r_pos == '0) || at_last_row || (c_pos == '0) || at_last_col;
        n_a_ctl.med    = (r_pos >= ROW_W'(2)) && (c_pos >= COL_W'(2));
        n_a_ctl.px     = i_in_data.pixel;
        n_a_ctl.row    = r_pos[OUT_ROW_W-1:0];
        n_a_ctl.col    = c_pos[OUT_COL_W-1:0];
    end

    // Hold configuration and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= clamp_w(COL_W'(RST_WIDTH));
            r_w_m1 <= clamp_w(COL_W'(RST_WIDTH)) - 1'b1;
            r_h    <= clamp_h(ROW_W'(RST_HEIGHT));
            r_h_m1 <= clamp_h(ROW_W'(RST_HEIGHT)) - 1'b1;
            r_col  <= '0;
            r_row  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IMAGE_WIDTH: begin
                        r_w    <= clamp_w(i_cfg_data[COL_W-1:0]);
                        r_w_m1 <= clamp_w(i_cfg_data[COL_W-1:0]) - 1'b1;
                    end
                    CFG_IMAGE_HEIGHT: begin
                        r_h    <= clamp_h(i_cfg_data[ROW_W-1:0]);
                        r_h_m1 <= clamp_h(i_cfg_data[ROW_W-1:0]) - 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // Advance stage valids every clock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_byp     <= 1'b0;
        end else begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_byp     <= r_a_valid && (ram_raddr == r_a_addr);
        end
    end

    // Advance stage payloads
    always_ff @(posedge i_clk) begin
        r_a_ctl    <= n_a_ctl;
        r_a_addr   <= ram_raddr;
        r_b_ctl    <= r_a_ctl;
        r_c_ctl    <= r_b_ctl;
        r_d_ctl    <= r_c_ctl;
        r_byp_data <= ram_wdata;
    end

    // Line buffers: upper byte is the row above, lower byte two rows above
    assign ram_raddr = AW'(c_pos);
    assign lines     = r_byp ? r_byp_data : ram_rdata;
    assign above1    = lines[2*PX_W-1:PX_W];
    assign above2    = lines[PX_W-1:0];
    assign ram_wdata = {r_a_ctl.px, above1};

    mf3_ram #(
        .WIDTH (2 * PX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (r_a_valid),
        .i_waddr (r_a_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Window: chain of column cells, new column enters on the right
    assign new_col = {r_a_ctl.px, above1, above2};

    for (genvar g = 0; g < 3; g++) begin : g_cell
        mf3_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (r_a_valid),
            .i_col   ((g == 2) ? new_col : win[(g + 1) % 3]),
            .o_col   (win[g])
        );
    end

    mf3_sort u_sort (
        .i_clk (i_clk),
        .i_win (win),
        .o_med (median)
    );

    // Queue pixels that yield at least one result
    assign q_push             = r_d_valid && (r_d_ctl.border || r_d_ctl.med);
    assign q_push_data.ctl    = r_d_ctl;
    assign q_push_data.median = median;

    mf3_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_valid     (o_out_valid),
        .o_data      (o_out_data),
        .i_stall     (i_out_stall),
        .o_count     (q_count)
    );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import mf3_pkg::*;

    localparam int MAX_W          = 1024;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int MAX_REPORTS    = 50;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Pixel channel
    logic in_valid = 1'b0;
    t_in  in_data  = '0;
    logic in_stall;

    // Result channel
    logic out_valid;
    t_out out_data;
    logic out_stall = 1'b0;

    // Register write port
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Filter state as seen by the predictor
    t_px              line_above  [MAX_W];
    t_px              line_above2 [MAX_W];
    t_px              win_cells   [9];
    int unsigned      pos_row;
    int unsigned      pos_col;
    logic [COL_W-1:0] reg_width;
    logic [ROW_W-1:0] reg_height;
    bit               restart_due;

    // Results still owed by the block, oldest first
    t_out pending_results [$];
    t_out oldest_result;
    int   mismatches = 0;

    // Traffic shaping
    bit          in_idle      = 1'b0;
    bit          out_idle     = 1'b0;
    int unsigned holdoff_req  = 0;
    int unsigned holdoff_seen = 0;
    int unsigned holdoff_left = 0;
    int unsigned stall_left   = 0;
    int unsigned cycle_count  = 0;

    median_filter_3x3_core #(
        .MAX_WIDTH (MAX_W)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sizes in effect after clamping
    function automatic int unsigned active_width();
        int unsigned v;
        v = 32'(reg_width);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > MAX_W) return MAX_W;
        return v;
    endfunction

    function automatic int unsigned active_height();
        int unsigned v;
        v = 32'(reg_height);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > MAX_HEIGHT) return MAX_HEIGHT;
        return v;
    endfunction

    function automatic void clear_filter_state();
        int i;
        for (i = 0; i < MAX_W; i++) begin
            line_above[i]  = '0;
            line_above2[i] = '0;
        end
        for (i = 0; i < 9; i++) win_cells[i] = '0;
        pos_row     = 0;
        pos_col     = 0;
        reg_width   = COL_W'(RST_WIDTH);
        reg_height  = ROW_W'(RST_HEIGHT);
        restart_due = 1'b0;
    endfunction

    // Median by rank: the cell with at most four smaller cells and at least five not larger
    function automatic t_px window_median();
        int  i;
        int  j;
        int  lower;
        int  equal;
        t_px pick;
        pick = '0;
        for (i = 0; i < 9; i++) begin
            lower = 0;
            equal = 0;
            for (j = 0; j < 9; j++) begin
                if (win_cells[j] < win_cells[i]) lower++;
                else if (win_cells[j] == win_cells[i]) equal++;
            end
            if (lower <= 4 && lower + equal > 4) pick = win_cells[i];
        end
        return pick;
    endfunction

    // Advance the filter by one pixel and queue the results it owes
    function automatic void filter_pixel(input t_px px, input logic fs);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        t_px         up1;
        t_px         up2;
        t_out        res;
        bit          on_border;
        bit          has_median;
        w = active_width();
        h = active_height();
        if (fs) begin
            pos_row = 0;
            pos_col = 0;
        end
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h) pos_row = 0;
        r = pos_row;
        c = pos_col;

        up1 = line_above[c];
        up2 = line_above2[c];
        line_above2[c] = up1;
        line_above[c]  = px;

        win_cells[0] = win_cells[1];
        win_cells[1] = win_cells[2];
        win_cells[2] = up2;
        win_cells[3] = win_cells[4];
        win_cells[4] = win_cells[5];
        win_cells[5] = up1;
        win_cells[6] = win_cells[7];
        win_cells[7] = win_cells[8];
        win_cells[8] = px;

        on_border  = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
        has_median = (r >= 2) && (c >= 2);
        if (on_border) begin
            res.value       = px;
            res.out_row     = r[OUT_ROW_W-1:0];
            res.out_col     = c[OUT_COL_W-1:0];
            res.from_median = 1'b0;
            res.last        = !has_median;
            pending_results.push_back(res);
        end
        if (has_median) begin
            res.value       = window_median();
            res.out_row     = r[OUT_ROW_W-1:0] - 1'b1;
            res.out_col     = c[OUT_COL_W-1:0] - 1'b1;
            res.from_median = 1'b1;
            res.last        = 1'b1;
            pending_results.push_back(res);
        end

        pos_col = c + 1;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row = r + 1;
            if (pos_row >= h) pos_row = 0;
        end
    endfunction

    // Send one pixel and update the prediction once it is taken
    task automatic push_pixel(input t_px px, input logic fs);
        int unsigned gap;
        t_in         item;
        gap = in_idle ? $urandom_range(0, 17) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.pixel       = px;
        item.frame_start = fs | restart_due;
        restart_due      = 1'b0;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        filter_pixel(item.pixel, item.frame_start);
    endtask

    // Drop valid and wait until every owed result is out and the pipe is empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A wider image would read line buffer columns never filled: restart the frame
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        int unsigned old_w;
        old_w = active_width();
        case (idx)
            CFG_IMAGE_WIDTH: begin
                reg_width = val[COL_W-1:0];
            end
            CFG_IMAGE_HEIGHT: begin
                reg_height = val[ROW_W-1:0];
            end
            default: begin
            end
        endcase
        if (active_width() > old_w) restart_due = 1'b1;
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic t_px random_pixel(input int unsigned mode);
        t_px base;
        base = t_px'($urandom_range(0, 252));
        case (mode)
            0: return base + t_px'($urandom_range(0, 3));
            1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return t_px'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_width();
        case ($urandom_range(0, 11))
            0: return CFG_DATA_W'($urandom_range(0, 2));
            1: return CFG_DATA_W'($urandom_range(13, 40));
            2: return CFG_DATA_W'($urandom);
            3: return CFG_DATA_W'(MAX_W);
            default: return CFG_DATA_W'($urandom_range(3, 12));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_height();
        case ($urandom_range(0, 9))
            0: return CFG_DATA_W'($urandom_range(0, 2));
            1: return CFG_DATA_W'($urandom);
            2: return CFG_DATA_W'(MAX_HEIGHT);
            default: return CFG_DATA_W'($urandom_range(3, 8));
        endcase
    endfunction

    // Row 0 border copies at the size left by reset
    task automatic test_reset_size();
        push_pixel(8'h00, 1'b0);
        push_pixel(8'hFF, 1'b0);
        push_pixel(8'h80, 1'b0);
        wait_idle();
    endtask

    // Shrink the width mid-row, clamp a tiny height, then wrap past the image end
    task automatic test_shrink_wrap();
        write_reg(CFG_IMAGE_WIDTH, 13'd3);
        push_pixel(8'hFF, 1'b0);
        push_pixel(8'h00, 1'b0);
        push_pixel(8'hFF, 1'b0);
        wait_idle();
        write_reg(CFG_IMAGE_HEIGHT, 13'd0);
        push_pixel(8'h00, 1'b0);
        push_pixel(8'hFF, 1'b0);
        push_pixel(8'h01, 1'b0);
        push_pixel(8'h7F, 1'b0);
        wait_idle();
    endtask

    // Oversized and truncated register values, then a height that leaves the current row outside the image
    task automatic test_clamps();
        int i;
        write_reg(CFG_IMAGE_WIDTH, 13'h1FFF);
        write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
        for (i = 0; i < 6; i++) push_pixel(random_pixel(2), 1'b0);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 13'd0);
        for (i = 0; i < 9; i++) push_pixel(random_pixel(2), 1'b0);
        wait_idle();
        write_reg(CFG_IMAGE_HEIGHT, 13'd4);
        for (i = 0; i < 3; i++) push_pixel(random_pixel(2), 1'b0);
        wait_idle();
    endtask

    // Hold the result side off while pixels keep coming, so the input stalls
    task automatic test_backpressure();
        int i;
        write_reg(CFG_IMAGE_WIDTH, 13'd7);
        write_reg(CFG_IMAGE_HEIGHT, 13'd5);
        in_idle  = 1'b0;
        out_idle = 1'b0;
        holdoff_req++;
        for (i = 0; i < 60; i++) push_pixel(random_pixel(2), i == 0);
        wait_idle();
    endtask

    // Pause mid-image until all results are out, then carry on
    task automatic test_pause_resume();
        int i;
        in_idle  = 1'b1;
        out_idle = 1'b1;
        for (i = 0; i < 20; i++) push_pixel(random_pixel(0), 1'b0);
        wait_idle();
        for (i = 0; i < 20; i++) push_pixel(random_pixel(2), 1'b0);
        wait_idle();
    endtask

    // Bursts that mostly start a new frame, with random content under random sizes and traffic
    task automatic test_random_frames();
        int unsigned sent;
        int unsigned burst;
        int unsigned k;
        int unsigned px_mode;
        bit          new_frame;
        logic        fs;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            in_idle  = ($urandom_range(0, 1) != 0);
            out_idle = ($urandom_range(0, 1) != 0);
            case ($urandom_range(0, 5))
                0: begin
                end
                1: write_reg(CFG_IMAGE_WIDTH, random_width());
                2: write_reg(CFG_IMAGE_HEIGHT, random_height());
                default: begin
                    write_reg(CFG_IMAGE_WIDTH, random_width());
                    write_reg(CFG_IMAGE_HEIGHT, random_height());
                end
            endcase
            new_frame = ($urandom_range(0, 6) != 0);
            px_mode   = $urandom_range(0, 3);
            burst     = $urandom_range(10, 80);
            for (k = 0; k < burst; k++) begin
                fs = (k == 0 && new_frame) || ($urandom_range(0, 63) == 0);
                push_pixel(random_pixel(px_mode), fs);
            end
            sent += burst;
        end
    endtask

    // Result side: random stall per result, plus long hold-offs on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (holdoff_seen != holdoff_req) begin
            holdoff_seen = holdoff_req;
            holdoff_left = HOLDOFF_CYCLES;
            out_stall <= 1'b1;
        end else if (holdoff_left != 0) begin
            holdoff_left--;
            out_stall <= (holdoff_left != 0);
        end else if (out_valid && !out_stall) begin
            stall_left = out_idle ? $urandom_range(0, 17) : 0;
            out_stall <= (stall_left != 0);
        end else if (stall_left != 0) begin
            stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            if (mismatches < MAX_REPORTS)
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Compare each taken result with the oldest one owed
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $error("result with nothing owed: value %0d row %0d col %0d",
                           out_data.value, out_data.out_row, out_data.out_col);
                mismatches++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("value", 32'(oldest_result.value), 32'(out_data.value));
                check_field("out_row", 32'(oldest_result.out_row),
                            32'(out_data.out_row));
                check_field("out_col", 32'(oldest_result.out_col),
                            32'(out_data.out_col));
                check_field("from_median", 32'(oldest_result.from_median),
                            32'(out_data.from_median));
                check_field("last", 32'(oldest_result.last), 32'(out_data.last));
            end
        end
    end

    // Give up on a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        clear_filter_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_size();
        test_shrink_wrap();
        test_clamps();
        test_backpressure();
        test_pause_resume();
        test_random_frames();

        // Drain, then watch for stray results
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/mf3_pkg.sv
rtl/mf3_ram.sv
rtl/mf3_cell.sv
rtl/mf3_sort.sv
rtl/mf3_outq.sv
rtl/median_filter_3x3_core.sv
tb/sv/testbench.sv
